// ===== src/rti_pkg.sv =====
// shared types and constants of the rgb to i420 converter
package rti_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int CFG_W       = 12;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int BANK_DEPTH  = MAX_WIDTH / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int BLK_W       = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int ACC_W       = 20;
    localparam int SUM_W       = 10;

    localparam int LUMA_KR       = 1225;
    localparam int LUMA_KG       = 2404;
    localparam int LUMA_KB       = 467;
    localparam int CHROMA_OFFSET = 128 << 12;
    localparam int CHROMA_KMAIN  = 512;
    localparam int U_KR          = 173;
    localparam int U_KG          = 339;
    localparam int V_KG          = 429;
    localparam int V_KB          = 83;
    localparam int FRAC_BITS     = 12;

    localparam logic [1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_SOURCE_IS_YUV = 2'd2;

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [COL_W:0]    t_width;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [ROW_W:0]    t_height;
    typedef logic [QCNT_W-1:0] t_qcnt;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [ACC_W-1:0]  t_acc;
    typedef logic [SUM_W-1:0]  t_sum;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_pix;

    typedef struct packed {
        t_pix p1;
        t_pix p2;
        t_pix p3;
        t_pix p4;
        logic yuv;
        t_blk block_column;
        t_blk block_row_flipped;
    } t_job;

endpackage

// ===== src/rti_pixel_if.sv =====
// pixel input channel
interface rti_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic       start_of_frame;

    modport source (output valid, byte_zero, byte_one, byte_two, start_of_frame, input ready);
    modport sink (input valid, byte_zero, byte_one, byte_two, start_of_frame, output ready);
endinterface

// ===== src/rti_block_if.sv =====
// 2x2 block output channel
interface rti_block_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [9:0] block_column;
    logic [9:0] block_row_flipped;

    modport source (
        output valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
               chroma_u, chroma_v, block_column, block_row_flipped,
        input  ready
    );
    modport sink (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
               chroma_u, chroma_v, block_column, block_row_flipped,
        output ready
    );
endinterface

// ===== src/rti_front.sv =====
// pixel front end: raster counters, even-row line buffer, block job assembly
module rti_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rti_pixel_if.sink                 i_pix,
    input  logic [rti_pkg::CFG_W-1:0] i_line_width,
    input  logic [rti_pkg::CFG_W-1:0] i_frame_height,
    input  logic                      i_source_is_yuv,
    input  rti_pkg::t_qcnt            i_queue_count,
    output logic                      o_job_valid,
    output rti_pkg::t_job             o_job
);

    rti_pkg::t_pix r_bank_even [rti_pkg::BANK_DEPTH];
    rti_pkg::t_pix r_bank_odd  [rti_pkg::BANK_DEPTH];

    rti_pkg::t_col    r_col, n_col;
    rti_pkg::t_row    r_row, n_row;
    rti_pkg::t_pix    r_left;
    logic             r_s1_valid;
    rti_pkg::t_pix    r_s1_left;
    rti_pkg::t_pix    r_s1_right;
    logic             r_s1_yuv;
    rti_pkg::t_blk    r_s1_col;
    rti_pkg::t_blk    r_s1_flip;
    rti_pkg::t_pix    r_even_q;
    rti_pkg::t_pix    r_odd_q;

    logic                         accept;
    rti_pkg::t_col                col;
    rti_pkg::t_row                row;
    rti_pkg::t_pix                px;
    logic [rti_pkg::BANK_AW-1:0]  addr;
    logic                         wr_even, wr_odd, rd_pair, hold_left;
    logic [rti_pkg::CFG_W-1:0]    w_raw, h_raw;
    rti_pkg::t_width              w_eff;
    rti_pkg::t_height             h_eff;
    rti_pkg::t_row                half_m1;
    rti_pkg::t_row                brow;
    rti_pkg::t_blk                flipped;

    assign i_pix.ready = ({1'b0, i_queue_count} + {{rti_pkg::QCNT_W{1'b0}}, r_s1_valid})
                         < (rti_pkg::QCNT_W + 1)'(rti_pkg::QUEUE_DEPTH);
    assign accept      = i_pix.valid && i_pix.ready;

    assign px   = '{r: i_pix.byte_two, g: i_pix.byte_one, b: i_pix.byte_zero};
    assign col  = i_pix.start_of_frame ? '0 : r_col;
    assign row  = i_pix.start_of_frame ? '0 : r_row;
    assign addr = col[rti_pkg::COL_W-1:1];

    assign wr_even   = accept && !row[0] && !col[0];
    assign wr_odd    = accept && !row[0] && col[0];
    assign hold_left = accept && row[0] && !col[0];
    assign rd_pair   = accept && row[0] && col[0];

    always_comb begin
        w_raw = {i_line_width[rti_pkg::CFG_W-1:1], 1'b0};
        if (w_raw < rti_pkg::CFG_W'(2)) begin
            w_eff = rti_pkg::t_width'(2);
        end else if (int'(w_raw) > rti_pkg::MAX_WIDTH) begin
            w_eff = rti_pkg::t_width'(rti_pkg::MAX_WIDTH);
        end else begin
            w_eff = rti_pkg::t_width'(w_raw);
        end
        h_raw = {i_frame_height[rti_pkg::CFG_W-1:1], 1'b0};
        if (h_raw < rti_pkg::CFG_W'(2)) begin
            h_eff = rti_pkg::t_height'(2);
        end else if (int'(h_raw) > rti_pkg::MAX_HEIGHT) begin
            h_eff = rti_pkg::t_height'(rti_pkg::MAX_HEIGHT);
        end else begin
            h_eff = rti_pkg::t_height'(h_raw);
        end
    end

    always_comb begin
        half_m1 = h_eff[rti_pkg::ROW_W:1] - rti_pkg::t_row'(1);
        brow    = rti_pkg::t_row'(row[rti_pkg::ROW_W-1:1]);
        flipped = (brow <= half_m1) ? rti_pkg::t_blk'(half_m1 - brow) : '0;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (({1'b0, col} + rti_pkg::t_width'(1)) >= w_eff) begin
                n_col = '0;
                n_row = (({1'b0, row} + rti_pkg::t_height'(1)) >= h_eff)
                        ? '0 : row + rti_pkg::t_row'(1);
            end else begin
                n_col = col + rti_pkg::t_col'(1);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= rd_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_even) begin
            r_bank_even[addr] <= px;
        end
        if (rd_pair) begin
            r_even_q <= r_bank_even[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_odd) begin
            r_bank_odd[addr] <= px;
        end
        if (rd_pair) begin
            r_odd_q <= r_bank_odd[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_left) begin
            r_left <= px;
        end
        if (rd_pair) begin
            r_s1_left  <= r_left;
            r_s1_right <= px;
            r_s1_yuv   <= i_source_is_yuv;
            r_s1_col   <= rti_pkg::t_blk'(addr);
            r_s1_flip  <= flipped;
        end
    end

    assign o_job_valid = r_s1_valid;
    always_comb begin
        o_job.p1                = r_even_q;
        o_job.p2                = r_odd_q;
        o_job.p3                = r_s1_left;
        o_job.p4                = r_s1_right;
        o_job.yuv               = r_s1_yuv;
        o_job.block_column      = r_s1_col;
        o_job.block_row_flipped = r_s1_flip;
    end

`ifndef NO_ASSERTIONS
    a_job_only_after_pair_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(rd_pair))
        else $error("job issued without a line buffer read");
`endif

endmodule

// ===== src/rti_queue.sv =====
// short job queue between front end and arithmetic back end
module rti_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rti_pkg::t_job  i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output rti_pkg::t_job  o_data,
    output rti_pkg::t_qcnt o_count
);

    rti_pkg::t_job  r_mem [rti_pkg::QUEUE_DEPTH];
    rti_pkg::t_qptr r_wr_ptr, r_rd_ptr;
    rti_pkg::t_qcnt r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + rti_pkg::t_qptr'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + rti_pkg::t_qptr'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + rti_pkg::t_qcnt'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - rti_pkg::t_qcnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == rti_pkg::t_qcnt'(rti_pkg::QUEUE_DEPTH)) |-> !i_push)
        else $error("queue overflow");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rti_pkg::t_qcnt'(rti_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== src/rti_back.sv =====
// arithmetic back end: luma, chroma and output register
module rti_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rti_pkg::t_job i_job,
    output logic          o_pop,
    rti_block_if.source   o_blk
);

    function automatic logic [7:0] luma_of(input rti_pkg::t_pix p);
        rti_pkg::t_acc acc;
        acc = rti_pkg::t_acc'(p.r) * rti_pkg::t_acc'(rti_pkg::LUMA_KR)
            + rti_pkg::t_acc'(p.g) * rti_pkg::t_acc'(rti_pkg::LUMA_KG)
            + rti_pkg::t_acc'(p.b) * rti_pkg::t_acc'(rti_pkg::LUMA_KB);
        return acc[rti_pkg::FRAC_BITS +: 8];
    endfunction

    logic          r_b1_valid;
    logic [7:0]    r_b1_luma [4];
    rti_pkg::t_sum r_b1_s0, r_b1_s1, r_b1_s2;
    logic          r_b1_yuv;
    rti_pkg::t_blk r_b1_col, r_b1_flip;

    logic          r_o_valid;
    logic [7:0]    r_o_luma [4];
    logic [7:0]    r_o_u, r_o_v;
    rti_pkg::t_blk r_o_col, r_o_flip;

    logic          out_free, b1_load;
    rti_pkg::t_acc u_acc, v_acc;

    assign out_free = !r_o_valid || o_blk.ready;
    assign b1_load  = !r_b1_valid || out_free;
    assign o_pop    = i_job_valid && b1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (b1_load) begin
                r_b1_valid <= i_job_valid;
            end
            if (out_free) begin
                r_o_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_luma[0] <= i_job.yuv ? i_job.p1.b : luma_of(i_job.p1);
            r_b1_luma[1] <= i_job.yuv ? i_job.p2.b : luma_of(i_job.p2);
            r_b1_luma[2] <= i_job.yuv ? i_job.p3.b : luma_of(i_job.p3);
            r_b1_luma[3] <= i_job.yuv ? i_job.p4.b : luma_of(i_job.p4);
            r_b1_s0 <= rti_pkg::t_sum'(i_job.p1.b) + rti_pkg::t_sum'(i_job.p2.b)
                     + rti_pkg::t_sum'(i_job.p3.b) + rti_pkg::t_sum'(i_job.p4.b);
            r_b1_s1 <= rti_pkg::t_sum'(i_job.p1.g) + rti_pkg::t_sum'(i_job.p2.g)
                     + rti_pkg::t_sum'(i_job.p3.g) + rti_pkg::t_sum'(i_job.p4.g);
            r_b1_s2 <= rti_pkg::t_sum'(i_job.p1.r) + rti_pkg::t_sum'(i_job.p2.r)
                     + rti_pkg::t_sum'(i_job.p3.r) + rti_pkg::t_sum'(i_job.p4.r);
            r_b1_yuv  <= i_job.yuv;
            r_b1_col  <= i_job.block_column;
            r_b1_flip <= i_job.block_row_flipped;
        end
    end

    always_comb begin
        u_acc = rti_pkg::t_acc'(rti_pkg::CHROMA_OFFSET)
              + rti_pkg::t_acc'(r_b1_s0) * rti_pkg::t_acc'(rti_pkg::CHROMA_KMAIN)
              - rti_pkg::t_acc'(r_b1_s2) * rti_pkg::t_acc'(rti_pkg::U_KR)
              - rti_pkg::t_acc'(r_b1_s1) * rti_pkg::t_acc'(rti_pkg::U_KG);
        v_acc = rti_pkg::t_acc'(rti_pkg::CHROMA_OFFSET)
              + rti_pkg::t_acc'(r_b1_s2) * rti_pkg::t_acc'(rti_pkg::CHROMA_KMAIN)
              - rti_pkg::t_acc'(r_b1_s1) * rti_pkg::t_acc'(rti_pkg::V_KG)
              - rti_pkg::t_acc'(r_b1_s0) * rti_pkg::t_acc'(rti_pkg::V_KB);
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_b1_valid) begin
            r_o_luma <= r_b1_luma;
            r_o_u    <= r_b1_yuv ? r_b1_s1[9:2] : u_acc[rti_pkg::FRAC_BITS +: 8];
            r_o_v    <= r_b1_yuv ? r_b1_s2[9:2] : v_acc[rti_pkg::FRAC_BITS +: 8];
            r_o_col  <= r_b1_col;
            r_o_flip <= r_b1_flip;
        end
    end

    assign o_blk.valid             = r_o_valid;
    assign o_blk.luma_top_left     = r_o_luma[0];
    assign o_blk.luma_top_right    = r_o_luma[1];
    assign o_blk.luma_bottom_left  = r_o_luma[2];
    assign o_blk.luma_bottom_right = r_o_luma[3];
    assign o_blk.chroma_u          = r_o_u;
    assign o_blk.chroma_v          = r_o_v;
    assign o_blk.block_column      = r_o_col;
    assign o_blk.block_row_flipped = r_o_flip;

`ifndef NO_ASSERTIONS
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_job_valid)
        else $error("pop without a queued job");
    a_stalled_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !out_free) |=> r_b1_valid)
        else $error("block lost in stalled stage");
`endif

endmodule

// ===== src/rgb_to_i420_converter.sv =====
// top level: configuration registers and the front, queue and back end
// Pixels arrive on i_pix in raster order, one transaction per pixel, with
// start_of_frame marking column 0 of row 0. Even-row pixels go into a line
// buffer of two 1024 x 24-bit banks (left and right pixel of each pair).
// On the right pixel of each pair in an odd row one 2x2 block transaction
// leaves on o_blk: four luma values, shared U and V, block column and the
// bottom-up block row. Other pixels produce no output.
// Throughput is one pixel per cycle while i_pix.ready is high; a block
// passes the line buffer read stage, the queue, the luma stage and the
// chroma stage on its way to o_blk.
// When o_blk stalls, blocks collect in the four-entry job queue and the
// pipeline registers; i_pix.ready drops once the queue and the line buffer
// read stage together hold four blocks.
// Registers on the APB port: 0x0 line_width, 0x4 frame_height,
// 0x8 source_is_yuv; write them only while no block is pending.
// Reset (synchronous, active low) clears the counters and all valid flags
// and sets the registers to 320, 240 and RGB mode; line buffer contents
// are not cleared.
module rgb_to_i420_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rti_pixel_if.sink   i_pix,
    rti_block_if.source o_blk
);

    logic [rti_pkg::CFG_W-1:0] r_line_width;
    logic [rti_pkg::CFG_W-1:0] r_frame_height;
    logic                      r_source_is_yuv;

    logic           wr_en;
    logic           job_valid, q_valid, q_pop;
    rti_pkg::t_job  job, q_job;
    rti_pkg::t_qcnt q_count;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= rti_pkg::CFG_W'(320);
            r_frame_height  <= rti_pkg::CFG_W'(240);
            r_source_is_yuv <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                rti_pkg::REG_LINE_WIDTH:    r_line_width    <= pwdata[rti_pkg::CFG_W-1:0];
                rti_pkg::REG_FRAME_HEIGHT:  r_frame_height  <= pwdata[rti_pkg::CFG_W-1:0];
                rti_pkg::REG_SOURCE_IS_YUV: r_source_is_yuv <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rti_pkg::REG_LINE_WIDTH:    prdata = 32'(r_line_width);
            rti_pkg::REG_FRAME_HEIGHT:  prdata = 32'(r_frame_height);
            rti_pkg::REG_SOURCE_IS_YUV: prdata = 32'(r_source_is_yuv);
            default:                    prdata = '0;
        endcase
    end

    rti_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (i_pix),
        .i_line_width    (r_line_width),
        .i_frame_height  (r_frame_height),
        .i_source_is_yuv (r_source_is_yuv),
        .i_queue_count   (q_count),
        .o_job_valid     (job_valid),
        .o_job           (job)
    );

    rti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job),
        .o_count (q_count)
    );

    rti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_blk       (o_blk)
    );

endmodule

// ===== tb/rti_block_checker.sv =====
// checker for the rgb to i420 converter: tracks registers, predicts 2x2 blocks and compares them
module rti_block_checker
    import rti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    rti_pixel_if        pix,
    rti_block_if        blk,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN    = 100;
    localparam int RESET_WIDTH  = 320;
    localparam int RESET_HEIGHT = 240;

    typedef struct packed {
        logic [7:0] y_tl;
        logic [7:0] y_tr;
        logic [7:0] y_bl;
        logic [7:0] y_br;
        logic [7:0] u;
        logic [7:0] v;
        t_blk       column;
        t_blk       row_flip;
    } i420_block_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             yuv_reg;
    t_pix             even_line [MAX_WIDTH];
    t_pix             odd_left;
    t_col             col_cnt;
    t_row             row_cnt;
    i420_block_t      blocks_due [$];
    int               faults = 0;

    assign o_errors = faults;

    function automatic int unsigned even_bound(input logic [CFG_W-1:0] raw,
                                               input int unsigned top);
        int unsigned v;
        v = {raw[CFG_W-1:1], 1'b0};
        if (v < 2) v = 2;
        if (v > top) v = top;
        return v;
    endfunction

    function automatic logic [7:0] luma_of_pixel(input t_pix p);
        logic [31:0] acc;
        acc = LUMA_KR * p.r + LUMA_KG * p.g + LUMA_KB * p.b;
        return 8'(acc >> FRAC_BITS);
    endfunction

    task automatic report_fault(input string msg);
        if (faults < MAX_SHOWN) $display("%0t ERROR: %s", $time, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want) report_fault($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // advance the raster position by one pixel and queue the block it completes
    task automatic take_pixel(input t_pix px, input logic sof);
        int unsigned w, h, col, row, half, brow;
        t_pix        tl, tr;
        logic [31:0] sum_b, sum_g, sum_r, u_acc, v_acc;
        i420_block_t want;
        w = even_bound(width_reg, MAX_WIDTH);
        h = even_bound(height_reg, MAX_HEIGHT);
        if (sof) begin
            col_cnt = '0;
            row_cnt = '0;
        end
        col = col_cnt;
        row = row_cnt;
        if (row % 2 == 0) begin
            even_line[col] = px;
        end else if (col % 2 == 0) begin
            odd_left = px;
        end else begin
            tl = even_line[col - 1];
            tr = even_line[col];
            sum_b = tl.b + tr.b + odd_left.b + px.b;
            sum_g = tl.g + tr.g + odd_left.g + px.g;
            sum_r = tl.r + tr.r + odd_left.r + px.r;
            if (yuv_reg) begin
                want.y_tl = tl.b;
                want.y_tr = tr.b;
                want.y_bl = odd_left.b;
                want.y_br = px.b;
                want.u    = 8'(sum_g >> 2);
                want.v    = 8'(sum_r >> 2);
            end else begin
                u_acc = (CHROMA_OFFSET + CHROMA_KMAIN * sum_b) - (U_KR * sum_r + U_KG * sum_g);
                v_acc = (CHROMA_OFFSET + CHROMA_KMAIN * sum_r) - (V_KG * sum_g + V_KB * sum_b);
                want.y_tl = luma_of_pixel(tl);
                want.y_tr = luma_of_pixel(tr);
                want.y_bl = luma_of_pixel(odd_left);
                want.y_br = luma_of_pixel(px);
                want.u    = 8'(u_acc >> FRAC_BITS);
                want.v    = 8'(v_acc >> FRAC_BITS);
            end
            half = h / 2;
            brow = row / 2;
            want.column   = t_blk'(col / 2);
            want.row_flip = (brow <= half - 1) ? t_blk'(half - 1 - brow) : '0;
            blocks_due.push_back(want);
        end
        if (col + 1 >= w) begin
            col_cnt = '0;
            row_cnt = (row + 1 >= h) ? '0 : t_row'(row + 1);
        end else begin
            col_cnt = t_col'(col + 1);
        end
    endtask

    task automatic compare_block(input i420_block_t got, input i420_block_t want);
        check_field("luma_top_left", got.y_tl, want.y_tl);
        check_field("luma_top_right", got.y_tr, want.y_tr);
        check_field("luma_bottom_left", got.y_bl, want.y_bl);
        check_field("luma_bottom_right", got.y_br, want.y_br);
        check_field("chroma_u", got.u, want.u);
        check_field("chroma_v", got.v, want.v);
        check_field("block_column", got.column, want.column);
        check_field("block_row_flipped", got.row_flip, want.row_flip);
    endtask

    always @(posedge i_clk) begin
        i420_block_t got;
        if (!i_rst_n) begin
            width_reg  = CFG_W'(RESET_WIDTH);
            height_reg = CFG_W'(RESET_HEIGHT);
            yuv_reg    = 1'b0;
            col_cnt    = '0;
            row_cnt    = '0;
            blocks_due.delete();
        end else begin
            if (pix.valid && pix.ready) begin
                take_pixel({pix.byte_two, pix.byte_one, pix.byte_zero}, pix.start_of_frame);
            end
            if (blk.valid && blk.ready) begin
                got.y_tl     = blk.luma_top_left;
                got.y_tr     = blk.luma_top_right;
                got.y_bl     = blk.luma_bottom_left;
                got.y_br     = blk.luma_bottom_right;
                got.u        = blk.chroma_u;
                got.v        = blk.chroma_v;
                got.column   = blk.block_column;
                got.row_flip = blk.block_row_flipped;
                if (blocks_due.size() == 0) begin
                    report_fault("block transaction with no block expected");
                end else begin
                    compare_block(got, blocks_due.pop_front());
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LINE_WIDTH:    width_reg  = pwdata[CFG_W-1:0];
                    REG_FRAME_HEIGHT:  height_reg = pwdata[CFG_W-1:0];
                    REG_SOURCE_IS_YUV: yuv_reg    = pwdata[0];
                    default: ;
                endcase
            end
        end
        o_pending <= blocks_due.size();
    end

endmodule

// ===== tb/tb_rgb_to_i420_converter.sv =====
// testbench top for the rgb to i420 converter: pixel stimulus, register writes, back-pressure
module tb_rgb_to_i420_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import rti_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_FROM    = 450;
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_GAP      = 5;

    localparam t_pix PX_BLACK = 24'h000000;
    localparam t_pix PX_WHITE = 24'hFFFFFF;
    localparam t_pix PX_RED   = 24'hFF0000;
    localparam t_pix PX_GREEN = 24'h00FF00;
    localparam t_pix PX_BLUE  = 24'h0000FF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          blocks_pending;
    int          faults;
    logic        src_idle_on = 1'b1;
    logic        sink_idle_on = 1'b1;
    int unsigned hold_orders = 0;

    rti_pixel_if pix ();
    rti_block_if blk ();

    rgb_to_i420_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix),
        .o_blk   (blk)
    );

    rti_block_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .pix       (pix),
        .blk       (blk),
        .o_pending (blocks_pending),
        .o_errors  (faults)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // output side: random stall bursts plus long hold-offs on request
    initial begin : block_sink
        int unsigned holds_done;
        holds_done = 0;
        blk.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_orders) begin
                holds_done++;
                blk.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                blk.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP) - 1) @(posedge i_clk);
            end else begin
                blk.ready <= 1'b1;
            end
        end
    end

    function automatic int unsigned usable_size(input int unsigned raw, input int unsigned top);
        int unsigned v;
        v = raw & 32'hFFE;
        if (v < 2) v = 2;
        if (v > top) v = top;
        return v;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {20'($urandom), value[11:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned wv, input int unsigned hv,
                             input int unsigned yuv);
        write_reg(REG_LINE_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_SOURCE_IS_YUV, yuv);
    endtask

    task automatic send_pixel(input t_pix px, input logic sof);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        pix.valid          <= 1'b1;
        pix.byte_zero      <= px.b;
        pix.byte_one       <= px.g;
        pix.byte_two       <= px.r;
        pix.start_of_frame <= sof;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic send_quad(input t_pix tl, input t_pix tr, input t_pix bl, input t_pix br);
        send_pixel(tl, 1'b1);
        send_pixel(tr, 1'b0);
        send_pixel(bl, 1'b0);
        send_pixel(br, 1'b0);
    endtask

    // raster of random pixels; noisy streams restart the frame now and then
    task automatic send_stream(input int unsigned count, input logic fresh_frame,
                               input logic noisy);
        for (int unsigned k = 0; k < count; k++) begin
            send_pixel(24'($urandom),
                       (k == 0) ? fresh_frame : (noisy && $urandom_range(0, 99) == 0));
        end
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (blocks_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned sent, wv, hv, rows, count;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix.valid          <= 1'b0;
        pix.byte_zero      <= '0;
        pix.byte_one       <= '0;
        pix.byte_two       <= '0;
        pix.start_of_frame <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first row and part of the second at the reset settings
        send_stream(320 + 40, 1'b1, 1'b1);
        settle();

        // single 2x2 frames at the smallest size
        configure(2, 2, 0);
        send_quad(PX_BLACK, PX_BLACK, PX_BLACK, PX_BLACK);
        send_quad(PX_WHITE, PX_WHITE, PX_WHITE, PX_WHITE);
        send_quad(PX_RED, PX_RED, PX_RED, PX_RED);
        send_quad(PX_GREEN, PX_GREEN, PX_GREEN, PX_GREEN);
        send_quad(PX_BLUE, PX_BLUE, PX_BLUE, PX_BLUE);
        settle();
        configure(2, 2, 1);
        send_quad(PX_WHITE, PX_BLACK, PX_RED, PX_BLUE);
        settle();

        // shrink width and height while the counters sit in an odd row past them
        configure(8, 8, 0);
        send_stream(3 * 8 + 5, 1'b1, 1'b0);
        settle();
        write_reg(REG_LINE_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 2);
        send_stream(1 + 4 * 4, 1'b0, 1'b0);
        settle();

        // output held off while pixels keep coming
        configure(8, 8, 1);
        src_idle_on  <= 1'b0;
        sink_idle_on <= 1'b0;
        hold_orders  <= hold_orders + 1;
        send_stream(16 * 8, 1'b1, 1'b0);
        settle();
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= CALM_FROM) begin
                src_idle_on  <= 1'b0;
                sink_idle_on <= 1'b0;
            end
            case ($urandom_range(0, 5))
                0: wv = 0;
                1: wv = 1;
                2: wv = 3;
                3: wv = 7;
                default: wv = $urandom_range(2, 24);
            endcase
            case ($urandom_range(0, 5))
                0: hv = 0;
                1: hv = 1;
                2: hv = 3;
                3: hv = 4095;
                default: hv = $urandom_range(2, 12);
            endcase
            configure(wv, hv, $urandom_range(0, 1));
            if (sent < CALM_FROM && $urandom_range(0, 3) == 0) hold_orders <= hold_orders + 1;
            rows  = $urandom_range(2, 10);
            count = rows * usable_size(wv, MAX_WIDTH) + $urandom_range(0, 3);
            send_stream(count, 1'b1, 1'b1);
            sent += count;
            settle();
        end

        if (faults == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
